FILE: hw/rtl/ira_pkg.sv
// ----------------------------------------------------------------------------
// IR range averaging package
// Shared widths, constants, register indexes and controller/datapath types.
// ----------------------------------------------------------------------------
package ira_pkg;

   localparam int WINDOW_LEN = 100;
   localparam int SAMPLE_W   = 10;
   localparam int SUM_W      = 17;
   localparam int DIST_W     = 17;
   localparam int THR_W      = 13;
   localparam int PTR_W      = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;

   // floor(sum / WINDOW_LEN) as (sum * RECIP_MULT) >> RECIP_SHIFT, exact for sums below 2^17
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_MULT  = ((2 ** RECIP_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
   localparam int RECIP_W     = $clog2(RECIP_MULT + 1);
   localparam int PROD_W      = SUM_W + RECIP_W;

   // linearisation: 6787 * 16 / (mean - 3) - 4 * 16
   localparam logic [DIST_W-1:0]   LIN_NUM_Q4    = DIST_W'(6787 * 16);
   localparam logic [DIST_W-1:0]   LIN_OFFSET_Q4 = DIST_W'(4 * 16);
   localparam logic [DIST_W-1:0]   DIST_MAX_Q4   = {DIST_W{1'b1}};
   localparam logic [SAMPLE_W-1:0] MEAN_BIAS     = SAMPLE_W'(3);

   localparam int DIV_STEPS = DIST_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS);

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = THR_W;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_RAW   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RAW   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [SAMPLE_W-1:0] MIN_RAW_RESET   = SAMPLE_W'(80);
   localparam logic [SAMPLE_W-1:0] MAX_RAW_RESET   = SAMPLE_W'(600);
   localparam logic [THR_W-1:0]    THRESHOLD_RESET = THR_W'(20);

   typedef struct packed {
      logic capture;   // clamp sample, read old window entry
      logic sum_upd;   // update running sum, write window, advance pointer
      logic mul;       // reciprocal multiply
      logic mean;      // take mean from product
      logic div_init;  // load divider
      logic div_step;  // one restoring division step
      logic load_out;  // register result, update presence
   } ctrl_cmd_type;

   typedef struct packed {
      logic div_last;
   } dp_status_type;

endpackage

FILE: hw/rtl/ir_range_average_presence.sv
// ----------------------------------------------------------------------------
// IR range average and presence detector
// Clamps samples, averages the last window, linearises to cm, flags presence.
// ----------------------------------------------------------------------------
// Each request transaction gives exactly one response transaction. Clamping
// and the window read happen in the accepting cycle. After acceptance the
// controller steps through the window update, the reciprocal multiply for the
// mean, divider set-up, the bit-serial restoring divider that forms
// 108592/(mean-3), and the result load, which waits until the output register
// is free. A new request is taken once the previous one has been registered,
// so no sample is accepted while the previous one is still in progress.
// The 100-entry window is cleared at reset through per-entry valid bits, so
// no clearing pass is needed. Write the clamp bounds and threshold only while
// no transaction is in flight.
module ir_range_average_presence (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [ira_pkg::SAMPLE_W-1:0]    req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ira_pkg::SAMPLE_W-1:0]    rsp_raw_average,
   output logic [ira_pkg::DIST_W-1:0]      rsp_distance_q4,
   output logic                            rsp_present,
   output logic                            rsp_release_pulse,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [ira_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ira_pkg::CSR_DAT_W-1:0]   csr_data
);

   ira_pkg::ctrl_cmd_type  cmd;
   ira_pkg::dp_status_type sts;

   assign csr_ready = 1'b1;

   ira_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   ira_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_sample        (req_sample),
      .csr_wr            (csr_valid),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_raw_average   (rsp_raw_average),
      .rsp_distance_q4   (rsp_distance_q4),
      .rsp_present       (rsp_present),
      .rsp_release_pulse (rsp_release_pulse)
   );

endmodule

FILE: hw/rtl/ira_ctrl.sv
// ----------------------------------------------------------------------------
// IR range averaging controller
// Sequences one transaction through the datapath and owns both handshakes.
// ----------------------------------------------------------------------------
module ira_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  ira_pkg::dp_status_type sts,
   output ira_pkg::ctrl_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SUM   = 3'd1;
   localparam logic [2:0] S_MUL   = 3'd2;
   localparam logic [2:0] S_MEAN  = 3'd3;
   localparam logic [2:0] S_DINIT = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_POST  = 3'd6;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SUM;
            end
         end
         S_SUM: begin
            cmd.sum_upd = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_MEAN;
         end
         S_MEAN: begin
            cmd.mean = 1'b1;
            state_in = S_DINIT;
         end
         S_DINIT: begin
            cmd.div_init = 1'b1;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) state_in = S_POST;
         end
         S_POST: begin
            // hold until the output register is free
            if (slot_free) begin
               cmd.load_out = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out)
         rsp_valid_in = 1'b1;
      else if (rsp_ready)
         rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: hw/rtl/ira_datapath.sv
// ----------------------------------------------------------------------------
// IR range averaging datapath
// Clamp, sample window, running mean, serial divider and presence logic.
// ----------------------------------------------------------------------------
module ira_datapath (
   input  logic                              clock,
   input  logic                              reset,
   input  ira_pkg::ctrl_cmd_type             cmd,
   output ira_pkg::dp_status_type            sts,
   input  logic [ira_pkg::SAMPLE_W-1:0]      req_sample,
   input  logic                              csr_wr,
   input  logic [ira_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ira_pkg::CSR_DAT_W-1:0]     csr_data,
   output logic [ira_pkg::SAMPLE_W-1:0]      rsp_raw_average,
   output logic [ira_pkg::DIST_W-1:0]        rsp_distance_q4,
   output logic                              rsp_present,
   output logic                              rsp_release_pulse
);

   localparam int SW = ira_pkg::SAMPLE_W;
   localparam int DW = ira_pkg::DIST_W;
   localparam int PW = ira_pkg::PTR_W;
   localparam int WL = ira_pkg::WINDOW_LEN;

   // configuration
   logic [SW-1:0]             min_raw_ff, max_raw_ff;
   logic [ira_pkg::THR_W-1:0] thr_cm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_raw_ff <= ira_pkg::MIN_RAW_RESET;
         max_raw_ff <= ira_pkg::MAX_RAW_RESET;
         thr_cm_ff  <= ira_pkg::THRESHOLD_RESET;
      end else if (csr_wr) begin
         case (csr_index)
            ira_pkg::CSR_MIN_RAW:   min_raw_ff <= csr_data[SW-1:0];
            ira_pkg::CSR_MAX_RAW:   max_raw_ff <= csr_data[SW-1:0];
            ira_pkg::CSR_THRESHOLD: thr_cm_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // clamp, upper bound first
   logic [SW-1:0] clamped;

   always_comb begin
      if (req_sample > max_raw_ff)
         clamped = max_raw_ff;
      else if (req_sample < min_raw_ff)
         clamped = min_raw_ff;
      else
         clamped = req_sample;
   end

   // sample window; an entry not yet written reads as zero
   logic [SW-1:0]          win_mem_ff [WL];
   logic [WL-1:0]          valid_ff;
   logic [SW-1:0]          rd_data_ff;
   logic                   rd_valid_ff;
   logic [SW-1:0]          s_ff;
   logic [PW-1:0]          wp_ff;
   logic [ira_pkg::SUM_W-1:0] sum_ff;
   logic [SW-1:0]          old_sample;

   assign old_sample = rd_valid_ff ? rd_data_ff : '0;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff  <= win_mem_ff[wp_ff];
         rd_valid_ff <= valid_ff[wp_ff];
         s_ff        <= clamped;
      end
      if (cmd.sum_upd)
         win_mem_ff[wp_ff] <= s_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         wp_ff    <= '0;
         sum_ff   <= '0;
      end else if (cmd.sum_upd) begin
         valid_ff[wp_ff] <= 1'b1;
         sum_ff <= sum_ff - ira_pkg::SUM_W'(old_sample) + ira_pkg::SUM_W'(s_ff);
         if (wp_ff == PW'(WL - 1))
            wp_ff <= '0;
         else
            wp_ff <= wp_ff + PW'(1);
      end
   end

   // mean by reciprocal multiply
   logic [ira_pkg::PROD_W-1:0] prod_ff;
   logic [SW-1:0]              mean_ff;

   always_ff @(posedge clock) begin
      if (cmd.mul)
         prod_ff <= ira_pkg::PROD_W'(sum_ff) *
                    ira_pkg::PROD_W'(ira_pkg::RECIP_MULT);
      if (cmd.mean)
         mean_ff <= prod_ff[ira_pkg::RECIP_SHIFT +: SW];
   end

   // restoring divider, one quotient bit a cycle
   logic [SW-1:0]                  rem_ff, den_ff;
   logic [DW-1:0]                  quo_ff;
   logic                           sat_ff;
   logic [ira_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [SW:0]                    rem_sh;
   logic [SW+1:0]                  diff;

   assign rem_sh       = {rem_ff, quo_ff[DW-1]};
   assign diff         = {1'b0, rem_sh} - {2'b00, den_ff};
   assign sts.div_last = (cnt_ff == ira_pkg::DIV_CNT_W'(ira_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         sat_ff <= (mean_ff <= ira_pkg::MEAN_BIAS);
         den_ff <= mean_ff - ira_pkg::MEAN_BIAS;
         rem_ff <= '0;
         quo_ff <= ira_pkg::LIN_NUM_Q4;
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + ira_pkg::DIV_CNT_W'(1);
         if (!diff[SW+1]) begin
            rem_ff <= diff[SW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[SW-1:0];
            quo_ff <= {quo_ff[DW-2:0], 1'b0};
         end
      end
   end

   // distance and presence decision
   logic [DW-1:0] dist_q4;
   logic [DW-1:0] thr_q4;
   logic          present_in, release_in;
   logic          present_ff;

   assign thr_q4 = {thr_cm_ff, 4'b0000};

   always_comb begin
      if (sat_ff)
         dist_q4 = ira_pkg::DIST_MAX_Q4;
      else if (quo_ff < ira_pkg::LIN_OFFSET_Q4)
         dist_q4 = '0;
      else
         dist_q4 = quo_ff - ira_pkg::LIN_OFFSET_Q4;
   end

   always_comb begin
      present_in = present_ff;
      release_in = 1'b0;
      if (dist_q4 < thr_q4) begin
         present_in = 1'b1;
      end else if (dist_q4 > thr_q4 && present_ff) begin
         present_in = 1'b0;
         release_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         present_ff <= 1'b0;
      else if (cmd.load_out)
         present_ff <= present_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         rsp_raw_average   <= mean_ff;
         rsp_distance_q4   <= dist_q4;
         rsp_present       <= present_in;
         rsp_release_pulse <= release_in;
      end
   end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// IR range average and presence detector testbench
// Drives raw samples through the valid/ready request channel, tracks window,
// mean, distance and presence in a local model and checks every response
// transaction field by field. A short table of directed rows comes first,
// then randomised phases under changing clamp bounds and thresholds.
// ----------------------------------------------------------------------------
module tb;

   localparam int          CYCLE_LIMIT  = 1_000_000;
   localparam int          RANDOM_ITEMS = 2000;
   localparam int          TAIL_CYCLES  = 40;
   localparam logic [ira_pkg::CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic [ira_pkg::SAMPLE_W-1:0] raw_average;
      logic [ira_pkg::DIST_W-1:0]   distance_q4;
      logic                         present;
      logic                         release_pulse;
   } ira_result_type;

   typedef enum logic [1:0] {ROW_SAMPLE, ROW_TYPED, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type                  kind;
      logic [ira_pkg::CSR_IDX_W-1:0] idx;
      logic [ira_pkg::CSR_DAT_W-1:0] data;   // sample value for sample rows
      ira_result_type                want;   // used by typed rows only
   } dir_row_type;

   localparam ira_result_type NO_RESULT = '0;
   localparam int             DIR_ROWS  = 28;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   logic [ira_pkg::SAMPLE_W-1:0]    req_sample = '0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   logic [ira_pkg::SAMPLE_W-1:0]    rsp_raw_average;
   logic [ira_pkg::DIST_W-1:0]      rsp_distance_q4;
   logic                            rsp_present;
   logic                            rsp_release_pulse;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [ira_pkg::CSR_IDX_W-1:0]   csr_index = '0;
   logic [ira_pkg::CSR_DAT_W-1:0]   csr_data = '0;

   ir_range_average_presence uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_sample        (req_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_raw_average   (rsp_raw_average),
      .rsp_distance_q4   (rsp_distance_q4),
      .rsp_present       (rsp_present),
      .rsp_release_pulse (rsp_release_pulse),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #5 clock = ~clock;

   // local copy of the block's state and registers
   logic [ira_pkg::SAMPLE_W-1:0]    win_entry [ira_pkg::WINDOW_LEN];
   int unsigned                     win_sum;
   int unsigned                     win_ptr;
   logic                            near_flag;
   logic [ira_pkg::SAMPLE_W-1:0]    cfg_min;
   logic [ira_pkg::SAMPLE_W-1:0]    cfg_max;
   logic [ira_pkg::THR_W-1:0]       cfg_thr;
   logic [ira_pkg::DIST_W-1:0]      last_dist;

   ira_result_type                  expected_results [$];
   logic [ira_pkg::SAMPLE_W-1:0]    eq_means [$];
   dir_row_type                     dir_rows [DIR_ROWS];

   int unsigned                     mismatches   = 0;
   int unsigned                     results_seen = 0;
   int unsigned                     cycle_count  = 0;
   int unsigned                     burst_left   = 0;
   int unsigned                     random_items = 0;
   logic [ira_pkg::SAMPLE_W-1:0]    run_value    = '0;
   int unsigned                     rdy_mode     = 0;
   int unsigned                     rdy_left     = 0;

   function automatic logic [ira_pkg::DIST_W-1:0] distance_of(
      input logic [ira_pkg::SAMPLE_W-1:0] mean);
      int unsigned q;
      if (mean <= 3) return ira_pkg::DIST_MAX_Q4;
      q = (6787 * 16) / (int'(mean) - 3);
      if (q < 4 * 16) return '0;
      q = q - 4 * 16;
      if (q > 131071) q = 131071;
      return q[ira_pkg::DIST_W-1:0];
   endfunction

   function automatic ira_result_type predict_sample(input logic [ira_pkg::SAMPLE_W-1:0] s);
      logic [ira_pkg::SAMPLE_W-1:0] clamped;
      int unsigned                  mean;
      int unsigned                  thr_q4;
      ira_result_type               r;
      clamped = s;
      // upper bound wins when the bounds are crossed
      if (clamped > cfg_max) clamped = cfg_max;
      else if (clamped < cfg_min) clamped = cfg_min;
      win_sum = win_sum - win_entry[win_ptr] + clamped;
      win_entry[win_ptr] = clamped;
      win_ptr = (win_ptr + 1) % ira_pkg::WINDOW_LEN;
      mean = win_sum / ira_pkg::WINDOW_LEN;
      r.raw_average   = mean[ira_pkg::SAMPLE_W-1:0];
      r.distance_q4   = distance_of(mean[ira_pkg::SAMPLE_W-1:0]);
      r.release_pulse = 1'b0;
      thr_q4 = int'(cfg_thr) * 16;
      if (r.distance_q4 < thr_q4) begin
         near_flag = 1'b1;
      end else if (r.distance_q4 > thr_q4 && near_flag) begin
         near_flag       = 1'b0;
         r.release_pulse = 1'b1;
      end
      r.present = near_flag;
      last_dist = r.distance_q4;
      return r;
   endfunction

   function automatic logic [ira_pkg::SAMPLE_W-1:0] next_sample(input int unsigned style);
      case (style)
         0: return ira_pkg::SAMPLE_W'($urandom_range(0, 1023));
         1: begin
            // hold a level, move it now and then
            if ($urandom_range(0, 15) == 0)
               run_value = ira_pkg::SAMPLE_W'($urandom_range(0, 1023));
            return run_value;
         end
         2: begin
            case ($urandom_range(0, 5))
               0: return '0;
               1: return '1;
               2: return cfg_min;
               3: return cfg_min - 1'b1;
               4: return cfg_max;
               default: return cfg_max + 1'b1;
            endcase
         end
         default: begin
            run_value = run_value + ira_pkg::SAMPLE_W'($urandom_range(0, 8));
            return run_value;
         end
      endcase
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch in %s at result %0d: got %0d, want %0d",
               what, results_seen, got, want);
      mismatches++;
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [ira_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ira_pkg::CSR_DAT_W-1:0] data);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         ira_pkg::CSR_MIN_RAW:   cfg_min = data[ira_pkg::SAMPLE_W-1:0];
         ira_pkg::CSR_MAX_RAW:   cfg_max = data[ira_pkg::SAMPLE_W-1:0];
         ira_pkg::CSR_THRESHOLD: cfg_thr = data[ira_pkg::THR_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic send_sample(input logic [ira_pkg::SAMPLE_W-1:0] s, input bit typed,
                              input ira_result_type want);
      int unsigned    gap;
      ira_result_type predicted;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 60);
      end
      req_valid  <= 1'b1;
      req_sample <= s;
      do @(posedge clock); while (!req_ready);
      predicted = predict_sample(s);
      expected_results.push_back(typed ? want : predicted);
      burst_left--;
   endtask

   function automatic logic [ira_pkg::CSR_DAT_W-1:0] raw_bound();
      logic [ira_pkg::CSR_DAT_W-1:0] v;
      v = ira_pkg::CSR_DAT_W'($urandom_range(4, 1023));
      // upper data bits are not part of the 10-bit bound
      if ($urandom_range(0, 7) == 0)
         v[ira_pkg::CSR_DAT_W-1:ira_pkg::SAMPLE_W] = 3'($urandom_range(1, 7));
      return v;
   endfunction

   // receiver: stretches of ready, random ready and long stalls
   always @(posedge clock) begin
      if (rdy_left == 0) begin
         rdy_mode = $urandom_range(0, 3);
         rdy_left = $urandom_range(1, 40);
      end else begin
         rdy_left--;
      end
      case (rdy_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= 1'($urandom_range(0, 1));
         2: rsp_ready <= 1'b0;
         default: rsp_ready <= ($urandom_range(0, 3) != 0);
      endcase
   end

   always @(posedge clock) begin
      ira_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("unexpected result", rsp_raw_average, 0);
         end else begin
            want = expected_results.pop_front();
            if (rsp_raw_average != want.raw_average)
               report_mismatch("raw_average", rsp_raw_average, want.raw_average);
            if (rsp_distance_q4 != want.distance_q4)
               report_mismatch("distance_q4", rsp_distance_q4, want.distance_q4);
            if (rsp_present != want.present)
               report_mismatch("present", rsp_present, want.present);
            if (rsp_release_pulse != want.release_pulse)
               report_mismatch("release_pulse", rsp_release_pulse, want.release_pulse);
         end
         results_seen++;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("[ir_range_average_presence] ERROR");
         $finish;
      end
   end

   initial begin
      int unsigned                  n;
      int unsigned                  style;
      logic [ira_pkg::SAMPLE_W-1:0] eq_m;
      logic [ira_pkg::DIST_W-1:0]   eq_d;

      foreach (win_entry[i]) win_entry[i] = '0;
      win_sum   = 0;
      win_ptr   = 0;
      near_flag = 1'b0;
      cfg_min   = ira_pkg::MIN_RAW_RESET;
      cfg_max   = ira_pkg::MAX_RAW_RESET;
      cfg_thr   = ira_pkg::THRESHOLD_RESET;
      last_dist = ira_pkg::DIST_MAX_Q4;

      // means whose distance is a whole number of cm, for the equal-threshold case
      for (int m = 4; m < 1024; m++) begin
         if (distance_of(ira_pkg::SAMPLE_W'(m)) % 16 == 0)
            eq_means.push_back(ira_pkg::SAMPLE_W'(m));
      end

      dir_rows = '{
         // window still mostly zeros: mean of three or less saturates
         '{ROW_TYPED,  ira_pkg::CSR_MIN_RAW,   13'd0,    '{10'd0, 17'd131071, 1'b0, 1'b0}},
         '{ROW_TYPED,  ira_pkg::CSR_MIN_RAW,   13'd0,    '{10'd1, 17'd131071, 1'b0, 1'b0}},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd1023, NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MIN_RAW,   13'd4,    NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MAX_RAW,   13'd1023, NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_THRESHOLD, 13'd8191, NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd1023, NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd512,  NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd341,  NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd682,  NO_RESULT},
         // zero threshold: the set flag drops with a release
         '{ROW_CSR,    ira_pkg::CSR_THRESHOLD, 13'd0,    NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd1,    NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd0,    NO_RESULT},
         // crossed bounds
         '{ROW_CSR,    ira_pkg::CSR_MIN_RAW,   13'd900,  NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MAX_RAW,   13'd100,  NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd1000, NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd50,   NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd100,  NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd500,  NO_RESULT},
         '{ROW_CSR,    CSR_UNUSED,             13'h1FFF, NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MIN_RAW,   13'd1023, NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MAX_RAW,   13'd1023, NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd7,    NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd1023, NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MIN_RAW,   13'd80,   NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_MAX_RAW,   13'd600,  NO_RESULT},
         '{ROW_CSR,    ira_pkg::CSR_THRESHOLD, 13'd20,   NO_RESULT},
         '{ROW_SAMPLE, ira_pkg::CSR_MIN_RAW,   13'd600,  NO_RESULT}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) begin
         case (dir_rows[i].kind)
            ROW_CSR:   csr_write(dir_rows[i].idx, dir_rows[i].data);
            ROW_TYPED: send_sample(dir_rows[i].data[ira_pkg::SAMPLE_W-1:0], 1'b1,
                                   dir_rows[i].want);
            default:   send_sample(dir_rows[i].data[ira_pkg::SAMPLE_W-1:0], 1'b0,
                                   NO_RESULT);
         endcase
      end

      while (random_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: begin
               csr_write(ira_pkg::CSR_MIN_RAW, ira_pkg::MIN_RAW_RESET);
               csr_write(ira_pkg::CSR_MAX_RAW, ira_pkg::MAX_RAW_RESET);
               csr_write(ira_pkg::CSR_THRESHOLD, ira_pkg::THRESHOLD_RESET);
            end
            1: begin
               csr_write(ira_pkg::CSR_MIN_RAW, 13'd4);
               csr_write(ira_pkg::CSR_MAX_RAW, 13'd1023);
               csr_write(ira_pkg::CSR_THRESHOLD,
                         ira_pkg::CSR_DAT_W'($urandom_range(0, 8191)));
            end
            2: begin
               // bounds drawn independently, so they cross now and then
               csr_write(ira_pkg::CSR_MIN_RAW, raw_bound());
               csr_write(ira_pkg::CSR_MAX_RAW, raw_bound());
               csr_write(ira_pkg::CSR_THRESHOLD,
                         ira_pkg::CSR_DAT_W'($urandom_range(0, 8191)));
               if ($urandom_range(0, 3) == 0)
                  csr_write(CSR_UNUSED, ira_pkg::CSR_DAT_W'($urandom_range(0, 8191)));
            end
            3: begin
               csr_write(ira_pkg::CSR_MIN_RAW, $urandom_range(0, 1) ? 13'd4 : 13'd1023);
               csr_write(ira_pkg::CSR_MAX_RAW, $urandom_range(0, 1) ? 13'd4 : 13'd1023);
               csr_write(ira_pkg::CSR_THRESHOLD, $urandom_range(0, 1) ? 13'd0 : 13'd8191);
            end
            4: begin
               // pin the mean, then walk the threshold from above the distance through equal to below
               eq_m = eq_means[$urandom_range(0, eq_means.size() - 1)];
               eq_d = distance_of(eq_m);
               csr_write(ira_pkg::CSR_MIN_RAW, ira_pkg::CSR_DAT_W'(eq_m));
               csr_write(ira_pkg::CSR_MAX_RAW, ira_pkg::CSR_DAT_W'(eq_m));
               repeat (ira_pkg::WINDOW_LEN) send_sample(next_sample(0), 1'b0, NO_RESULT);
               csr_write(ira_pkg::CSR_THRESHOLD, ira_pkg::CSR_DAT_W'(eq_d / 16 + 1));
               repeat (4) send_sample(next_sample(0), 1'b0, NO_RESULT);
               csr_write(ira_pkg::CSR_THRESHOLD, ira_pkg::CSR_DAT_W'(eq_d / 16));
               repeat (8) send_sample(next_sample(0), 1'b0, NO_RESULT);
               csr_write(ira_pkg::CSR_THRESHOLD, ira_pkg::CSR_DAT_W'(eq_d / 16 - 1));
               repeat (4) send_sample(next_sample(0), 1'b0, NO_RESULT);
               random_items += ira_pkg::WINDOW_LEN + 16;
            end
            default: begin
               // threshold close to where the distance sits now
               csr_write(ira_pkg::CSR_MIN_RAW, raw_bound());
               csr_write(ira_pkg::CSR_MAX_RAW, 13'd1023);
               n = last_dist / 16 + $urandom_range(0, 2);
               csr_write(ira_pkg::CSR_THRESHOLD,
                         ira_pkg::CSR_DAT_W'((n == 0) ? 0 : ((n > 8192) ? 8191 : n - 1)));
            end
         endcase
         n     = $urandom_range(30, 160);
         style = $urandom_range(0, 3);
         repeat (n) send_sample(next_sample(style), 1'b0, NO_RESULT);
         random_items += n;
      end

      wait_idle();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("[ir_range_average_presence] OK");
      end else begin
         $display("[ir_range_average_presence] ERROR");
      end
      $finish;
   end

endmodule
